### hw/rtl/nis_pkg.sv
// Shared types and constants of the number and identifier scanner.
// No dependencies; used by every module of the scanner but nis_queue.

package nis_pkg;

  // identifier length limit after reset
  localparam logic [7:0] MAX_LEN_RST = 8'd32;

  // token kind codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_NUM   = 2'd1;
  localparam logic [1:0] KIND_IDENT = 2'd2;

  // character codes the scanner looks for
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // scanner phases, one-hot
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0_0000_0000_0001,
    S_NSTART = 13'b0_0000_0000_0010,
    S_NPFX   = 13'b0_0000_0000_0100,
    S_NPFX0  = 13'b0_0000_0000_1000,
    S_NZERO  = 13'b0_0000_0001_0000,
    S_HEXW   = 13'b0_0000_0010_0000,
    S_HEXD   = 13'b0_0000_0100_0000,
    S_OCTW   = 13'b0_0000_1000_0000,
    S_OCTD   = 13'b0_0001_0000_0000,
    S_DECW   = 13'b0_0010_0000_0000,
    S_DECD   = 13'b0_0100_0000_0000,
    S_IDW    = 13'b0_1000_0000_0000,
    S_IDD    = 13'b1_0000_0000_0000
  } phase_t;

  // one input transaction
  typedef struct packed {
    logic       action;
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic        taken;
    logic        done_res;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        ident_char_valid;
    logic [7:0]  ident_char;
    logic [7:0]  ident_length;
  } result_t;

  // character after classification by the front end
  typedef struct packed {
    logic       action;
    logic       end_of_text;
    logic [7:0] ch;
    logic       is_space;
    logic       is_letus;    // letter or underscore
    logic       is_dec;
    logic       is_oct;
    logic       is_hex;
    logic [3:0] dval;        // digit value when is_hex
    logic       is_hd;       // hash or dollar prefix
    logic       is_zero;
    logic       is_x;
  } cls_item_t;

endpackage

### hw/rtl/nis_queue.sv
// Small register queue used between the scanner stages and at the result side.
// No package dependency; width and depth come from parameters.

module nis_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/nis_front.sv
// Front end of the scanner: accepts characters and classifies them.
// Depends on nis_pkg for the item types and character codes.

module nis_front (
  input  nis_pkg::in_item_t  item,
  output nis_pkg::cls_item_t cls
);

  logic [7:0] c;
  logic       lower_af, upper_af;

  assign c = item.ch;

  // hex letters a-f and A-F
  assign lower_af = (c >= 8'h61) && (c <= 8'h66);
  assign upper_af = (c >= 8'h41) && (c <= 8'h46);

  // character classes
  always_comb begin
    cls.action      = item.action;
    cls.end_of_text = item.end_of_text;
    cls.ch          = c;
    cls.is_space    = (c == nis_pkg::CH_SPACE) || (c == nis_pkg::CH_TAB) ||
                      (c == nis_pkg::CH_LF) || (c == nis_pkg::CH_CR);
    cls.is_letus    = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                      (c == nis_pkg::CH_UNDER);
    cls.is_dec      = (c >= 8'h30) && (c <= 8'h39);
    cls.is_oct      = (c >= 8'h30) && (c <= 8'h37);
    cls.is_hex      = cls.is_dec || lower_af || upper_af;
    cls.dval        = cls.is_dec ? c[3:0] : c[3:0] + 4'd9;
    cls.is_hd       = (c == nis_pkg::CH_HASH) || (c == nis_pkg::CH_DOLLAR);
    cls.is_zero     = (c == nis_pkg::CH_ZERO);
    cls.is_x        = (c == nis_pkg::CH_X);
  end

endmodule

### hw/rtl/nis_back.sv
// Back end of the scanner: phase machine, number accumulator, identifier count.
// Depends on nis_pkg for the phase enum, item types and kind codes.

module nis_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               fire,
  input  nis_pkg::cls_item_t cls,
  output nis_pkg::result_t   res
);

  nis_pkg::phase_t       state_r, state_nxt, ph, wp;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt, acc_base, acc_new, acc_sh;
  logic [7:0]            cnt_r, cnt_nxt, cnt_base, cnt_new;
  logic [7:0]            max_len_r;
  logic                  taken, done, store, run, is_ident;
  logic                  num, dig_ok, waiting;
  nis_pkg::phase_t       dig_ph;
  logic [31:0]           acc_out;

  // state at the start of this transaction, a new scan when idle
  always_comb begin
    if (state_r == nis_pkg::S_IDLE) begin
      ph       = cls.action ? nis_pkg::S_IDW : nis_pkg::S_NSTART;
      acc_base = '0;
      cnt_base = '0;
    end else begin
      ph       = state_r;
      acc_base = acc_r;
      cnt_base = cnt_r;
    end
  end

  assign is_ident = (ph == nis_pkg::S_IDW) || (ph == nis_pkg::S_IDD);

  // phase step for one character
  always_comb begin
    taken     = 1'b0;
    done      = 1'b0;
    store     = 1'b0;
    run       = 1'b0;
    wp        = ph;
    state_nxt = ph;
    acc_new   = acc_base;
    cnt_new   = cnt_base;
    num       = 1'b0;
    dig_ok    = 1'b0;
    waiting   = 1'b0;
    dig_ph    = ph;
    acc_sh    = acc_base;

    if (cls.end_of_text) begin
      done = 1'b1;
    end else begin
      // prefix handling and identifier wait, falls through to digit or identifier work
      unique case (ph) inside
        nis_pkg::S_NSTART: begin
          if (cls.is_hd) begin
            state_nxt = nis_pkg::S_NPFX;
            taken     = 1'b1;
          end else if (cls.is_zero) begin
            state_nxt = nis_pkg::S_NZERO;
            taken     = 1'b1;
          end else begin
            wp  = nis_pkg::S_DECW;
            run = 1'b1;
          end
        end
        nis_pkg::S_NPFX: begin
          if (cls.is_zero) begin
            state_nxt = nis_pkg::S_NPFX0;
            taken     = 1'b1;
          end else begin
            wp  = nis_pkg::S_HEXW;
            run = 1'b1;
          end
        end
        nis_pkg::S_NPFX0, nis_pkg::S_NZERO: begin
          if (cls.is_x) begin
            state_nxt = nis_pkg::S_HEXW;
            taken     = 1'b1;
          end else begin
            wp  = (ph == nis_pkg::S_NPFX0) ? nis_pkg::S_HEXW : nis_pkg::S_OCTW;
            run = 1'b1;
          end
        end
        nis_pkg::S_IDW: begin
          if (max_len_r == '0) begin
            done = 1'b1;
          end else if (cls.is_space) begin
            taken = 1'b1;
          end else if (cls.is_letus) begin
            wp  = nis_pkg::S_IDD;
            run = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          run = 1'b1;
        end
      endcase

      // digit and identifier work
      if (run) begin
        unique case (wp) inside
          nis_pkg::S_HEXW, nis_pkg::S_HEXD: begin
            num     = 1'b1;
            dig_ok  = cls.is_hex;
            waiting = (wp == nis_pkg::S_HEXW);
            dig_ph  = nis_pkg::S_HEXD;
            acc_sh  = acc_base << 4;
          end
          nis_pkg::S_OCTW, nis_pkg::S_OCTD: begin
            num     = 1'b1;
            dig_ok  = cls.is_oct;
            waiting = (wp == nis_pkg::S_OCTW);
            dig_ph  = nis_pkg::S_OCTD;
            acc_sh  = acc_base << 3;
          end
          nis_pkg::S_DECW, nis_pkg::S_DECD: begin
            num     = 1'b1;
            dig_ok  = cls.is_dec;
            waiting = (wp == nis_pkg::S_DECW);
            dig_ph  = nis_pkg::S_DECD;
            acc_sh  = (acc_base << 3) + (acc_base << 1);
          end
          nis_pkg::S_IDD: begin
            if (cnt_base >= max_len_r) begin
              done = 1'b1;
            end else if (cls.is_letus || cls.is_dec) begin
              cnt_new   = cnt_base + 8'd1;
              taken     = 1'b1;
              store     = 1'b1;
              state_nxt = nis_pkg::S_IDD;
              done      = (cnt_base + 8'd1) >= max_len_r;
            end else begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase

        if (num) begin
          if (dig_ok) begin
            acc_new   = acc_sh + {{(VALUE_BITS-4){1'b0}}, cls.dval};
            state_nxt = dig_ph;
            taken     = 1'b1;
          end else if (waiting && cls.is_space) begin
            state_nxt = wp;
            taken     = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
      end
    end

    // a finished scan returns to idle
    if (done) begin
      state_nxt = nis_pkg::S_IDLE;
      acc_nxt   = '0;
      cnt_nxt   = '0;
    end else begin
      acc_nxt = acc_new;
      cnt_nxt = cnt_new;
    end
  end

  // low 32 bits of the accumulator
  generate
    if (VALUE_BITS >= 32) begin : g_wide
      assign acc_out = acc_new[31:0];
    end else begin : g_narrow
      assign acc_out = {{(32-VALUE_BITS){1'b0}}, acc_new};
    end
  endgenerate

  // result transaction
  always_comb begin
    res.taken            = taken;
    res.done_res         = done;
    res.kind             = !done ? nis_pkg::KIND_NONE :
                           !is_ident ? nis_pkg::KIND_NUM :
                           (cnt_new != '0) ? nis_pkg::KIND_IDENT : nis_pkg::KIND_NONE;
    res.value            = is_ident ? '0 : acc_out;
    res.ident_char_valid = store;
    res.ident_char       = store ? cls.ch : '0;
    res.ident_length     = is_ident ? cnt_new : '0;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nis_pkg::S_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= nis_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

endmodule

### hw/rtl/number_and_identifier_scanner.sv
// Number and identifier scanner, top level: one character in, one result out per transaction.
// Takes one character per clock while full is low and returns one result per character, in
// order. A character accepted on push is first stored in the classified-character queue, then
// the phase machine writes its result into the result queue, whose head is shown while empty
// is low. Both queues hold two entries, so a new character is taken every cycle as long as
// results are popped; the phase machine updates the accumulator and identifier count for each
// character it takes from the classified-character queue. Nothing needs clearing after reset.
// Depends on nis_pkg, nis_front, nis_queue and nis_back.

module number_and_identifier_scanner #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nis_pkg::in_item_t  in_data,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output nis_pkg::result_t   out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  localparam int CLS_W = $bits(nis_pkg::cls_item_t);
  localparam int RES_W = $bits(nis_pkg::result_t);

  nis_pkg::cls_item_t cls_in, cls_head;
  nis_pkg::result_t   res;
  logic [CLS_W-1:0]   cls_rdata;
  logic [RES_W-1:0]   res_rdata;
  logic               mid_empty, res_full, fire;

  // classify the incoming character
  nis_front u_front (
    .item (in_data),
    .cls  (cls_in)
  );

  // queue between front and back
  nis_queue #(.WIDTH(CLS_W), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls_in),
    .full  (full),
    .pop   (fire),
    .rdata (cls_rdata),
    .empty (mid_empty)
  );

  assign cls_head = nis_pkg::cls_item_t'(cls_rdata);
  assign fire     = !mid_empty && !res_full;

  // phase machine
  nis_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .cls       (cls_head),
    .res       (res)
  );

  // result queue
  nis_queue #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_data = nis_pkg::result_t'(res_rdata);

endmodule

### hw/rtl/nis_checker.sv
// Port-level checks for the number and identifier scanner, bound to the top level.
// Depends on nis_pkg for the result type and kind codes.

module nis_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input nis_pkg::result_t out_data
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("scanner not empty after reset");

  // a stored character is always consumed and counted
  a_store_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.ident_char_valid) |->
      (out_data.taken && out_data.ident_length != 8'd0 && out_data.value == 32'd0))
    else $error("identifier store without consume");

  // kind is only reported when the scan finishes
  a_kind_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.done_res) |-> (out_data.kind == nis_pkg::KIND_NONE))
    else $error("kind set on unfinished scan");

  // a character that is not stored leaves the character field clear
  a_char_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.ident_char_valid) |-> (out_data.ident_char == 8'd0))
    else $error("identifier character without store");

  // a waiting result holds while not popped
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while waiting");

endmodule

bind number_and_identifier_scanner nis_checker u_nis_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

### tb/nis_checker.sv
`timescale 1ns / 1ps
// Checker for the number and identifier scanner: watches the character, result and
// register ports, predicts every result and compares it field by field.
// Depends on nis_pkg for the transaction types, kind codes, character codes and phases.

module nis_tb_checker
  import nis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_data,
  input  logic      pop,
  input  logic      empty,
  input  result_t   out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  output int        fail_count,
  output int        pending
);

  // predicted scanner state and register copy
  phase_t      scan_state;
  logic [31:0] number_acc;
  logic [7:0]  ident_count;
  logic [7:0]  ident_limit;
  result_t     expected_results[$];

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // digit value in radix 8, 10 or 16, -1 when c is no digit
  function automatic int digit_val(logic [7:0] c, int radix);
    if (radix == 8) return (c >= "0" && c <= "7") ? int'(c - CH_ZERO) : -1;
    if (c >= "0" && c <= "9") return int'(c - CH_ZERO);
    if (radix == 16 && c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (radix == 16 && c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // one character through the scanner, updates the predicted state
  function automatic result_t scan_char(in_item_t it);
    result_t     r;
    logic [7:0]  c;
    phase_t      p;
    bit          ident, again, stop, took, keep, waiting;
    int          radix, d;
    r = '0;
    c = it.ch;
    stop = 1'b0;
    took = 1'b0;
    keep = 1'b0;
    if (scan_state == S_IDLE) begin
      number_acc = '0;
      ident_count = '0;
      scan_state = it.action ? S_IDW : S_NSTART;
    end
    ident = (scan_state == S_IDW || scan_state == S_IDD);

    if (it.end_of_text) begin
      stop = 1'b1;
    end else begin
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        p = scan_state;
        case (p)
          // optional hash or dollar prefix, or a leading zero
          S_NSTART: begin
            if (c == CH_HASH || c == CH_DOLLAR) begin
              scan_state = S_NPFX;
              took = 1'b1;
            end else if (c == CH_ZERO) begin
              scan_state = S_NZERO;
              took = 1'b1;
            end else begin
              scan_state = S_DECW;
              again = 1'b1;
            end
          end
          S_NPFX: begin
            if (c == CH_ZERO) begin
              scan_state = S_NPFX0;
              took = 1'b1;
            end else begin
              scan_state = S_HEXW;
              again = 1'b1;
            end
          end
          // zero seen, lowercase x turns to hex
          S_NPFX0, S_NZERO: begin
            if (c == CH_X) begin
              scan_state = S_HEXW;
              took = 1'b1;
            end else begin
              scan_state = (p == S_NPFX0) ? S_HEXW : S_OCTW;
              again = 1'b1;
            end
          end
          // digit phases, blanks skipped before the first digit
          S_HEXW, S_HEXD, S_OCTW, S_OCTD, S_DECW, S_DECD: begin
            radix = (p == S_HEXW || p == S_HEXD) ? 16 :
                    (p == S_OCTW || p == S_OCTD) ? 8 : 10;
            waiting = (p == S_HEXW || p == S_OCTW || p == S_DECW);
            d = digit_val(c, radix);
            if (d >= 0) begin
              if (radix == 16) number_acc = (number_acc << 4) + 32'(d);
              else if (radix == 8) number_acc = (number_acc << 3) + 32'(d);
              else number_acc = number_acc * 32'd10 + 32'(d);
              if (p == S_HEXW) scan_state = S_HEXD;
              else if (p == S_OCTW) scan_state = S_OCTD;
              else if (p == S_DECW) scan_state = S_DECD;
              took = 1'b1;
            end else if (waiting && is_blank(c)) begin
              took = 1'b1;
            end else begin
              stop = 1'b1;
            end
          end
          S_IDW: begin
            if (ident_limit == 8'd0) stop = 1'b1;
            else if (is_blank(c)) took = 1'b1;
            else if (is_letter(c) || c == CH_UNDER) begin
              scan_state = S_IDD;
              again = 1'b1;
            end else stop = 1'b1;
          end
          // identifier body, bounded by the length limit
          default: begin
            if (ident_count >= ident_limit) begin
              stop = 1'b1;
            end else if (is_letter(c) || (c >= "0" && c <= "9") || c == CH_UNDER) begin
              ident_count = ident_count + 8'd1;
              took = 1'b1;
              keep = 1'b1;
              if (ident_count >= ident_limit) stop = 1'b1;
            end else begin
              stop = 1'b1;
            end
          end
        endcase
      end
    end

    r.taken = took;
    r.done_res = stop;
    r.kind = !stop ? KIND_NONE : !ident ? KIND_NUM :
             (ident_count > 8'd0) ? KIND_IDENT : KIND_NONE;
    r.value = ident ? '0 : number_acc;
    r.ident_char_valid = keep;
    r.ident_char = keep ? c : 8'd0;
    r.ident_length = ident ? ident_count : 8'd0;

    if (stop) begin
      scan_state = S_IDLE;
      number_acc = '0;
      ident_count = '0;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // compare results, predict characters, follow register writes
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      scan_state = S_IDLE;
      number_acc = '0;
      ident_count = '0;
      ident_limit = MAX_LEN_RST;
      expected_results.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no character waiting for it");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("taken", 32'(want.taken), 32'(out_data.taken));
          check_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
          check_field("kind", 32'(want.kind), 32'(out_data.kind));
          check_field("value", want.value, out_data.value);
          check_field("ident_char_valid", 32'(want.ident_char_valid),
                      32'(out_data.ident_char_valid));
          check_field("ident_char", 32'(want.ident_char), 32'(out_data.ident_char));
          check_field("ident_length", 32'(want.ident_length), 32'(out_data.ident_length));
        end
      end
      if (push && !full) expected_results.push_back(scan_char(in_data));
      if (cfg_we) ident_limit = cfg_wdata;
    end
    pending = expected_results.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, character and register stimulus, result
// draining with random stalls, watchdog and verdict. Depends on nis_pkg, the scanner
// top level number_and_identifier_scanner and the checker nis_tb_checker.

module testbench;
  import nis_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 115;

  logic       clk;
  logic       rst_n;
  logic       push;
  in_item_t   in_data;
  logic       full;
  logic       empty;
  logic       pop;
  result_t    out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         pending;

  int         sent;
  bit         quiet;
  logic       tok_action;
  int         pop_stall;
  int         idle_cycles;

  number_and_identifier_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nis_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .pop        (pop),
    .empty      (empty),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one character transaction, with an occasional gap before it
  task automatic send(logic action, logic [7:0] c, logic eot);
    if (!quiet && (sent % 96) < 64 && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    push <= 1'b1;
    in_data.action <= action;
    in_data.ch <= c;
    in_data.end_of_text <= eot;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // token character: the first carries the scan action, the rest a random one
  task automatic put(logic [7:0] c);
    send(tok_action, c, 1'b0);
    tok_action = 1'($urandom_range(0, 1));
  endtask

  task automatic put_text(logic action, string s);
    tok_action = action;
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // register write once the scanner has answered every character
  task automatic write_limit(logic [7:0] v);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(int radix);
    int d;
    d = $urandom_range(0, radix - 1);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(d - 10);
  endfunction

  function automatic logic [7:0] word_char(bit lead);
    int r;
    r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (!lead && r < 62) return CH_ZERO + 8'(r - 52);
    return CH_UNDER;
  endfunction

  // end a token with a delimiter or a random byte, or now and then with end of text
  task automatic finish_token();
    if ($urandom_range(0, 9) == 0) begin
      send(tok_action, 8'($urandom_range(0, 255)), 1'b1);
    end else if ($urandom_range(0, 1)) begin
      put(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0: put(CH_SPACE);
        1: put(",");
        2: put(";");
        default: put(")");
      endcase
    end
  endtask

  task automatic emit_number();
    int pfx, radix;
    tok_action = 1'b0;
    pfx = $urandom_range(0, 6);
    radix = (pfx == 0) ? 10 : (pfx == 6) ? 8 : 16;
    case (pfx)
      1: put(CH_HASH);
      2: begin put(CH_HASH); put(CH_ZERO); put(CH_X); end
      3: put(CH_DOLLAR);
      4: begin put(CH_DOLLAR); put(CH_ZERO); put(CH_X); end
      5: begin put(CH_ZERO); put(CH_X); end
      6: put(CH_ZERO);
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(blank_char());
    // long runs make the value wrap
    repeat (($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8))
      put(digit_char(radix));
    finish_token();
  endtask

  task automatic emit_ident(int body_len);
    tok_action = 1'b1;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(blank_char());
    put(word_char(1'b1));
    repeat (body_len) put(word_char(1'b0));
    finish_token();
  endtask

  task automatic emit_token();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) emit_number();
    else if (r < 15)
      emit_ident(($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10));
    else if (r < 18)
      repeat ($urandom_range(1, 4))
        send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
    else send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // result side: pops with random stall bursts
  initial begin
    pop = 1'b0;
    pop_stall = 0;
    forever begin
      @(negedge clk);
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        pop_stall = $urandom_range(0, 5);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] limits[6];
    int target;
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    sent = 0;
    quiet = 1'b0;
    tok_action = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: end of text on an idle scanner, both scan kinds
    send(1'b0, 8'hFF, 1'b1);
    send(1'b1, 8'h00, 1'b1);
    // hash with 0x, hex after dollar and zero, octal
    put_text(1'b0, "#0xF,");
    put_text(1'b0, "$0b ");
    put_text(1'b0, "017,");
    // identifier after blanks, closed by a non-ascii byte
    put_text(1'b1, " _z9");
    put(8'h80);
    // identifier scan that meets a digit first
    put_text(1'b1, "9");
    // limit lowered below the count in the middle of an identifier
    put_text(1'b1, "ab");
    write_limit(8'd1);
    put("c");

    // random phases, one length limit each
    limits = '{MAX_LEN_RST, 8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(2, 254))};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      if (k == $size(limits) - 1) quiet = 1'b1;
      target = sent + PHASE_ITEMS;
      if (limits[k] == 8'd255) emit_ident(258);
      while (sent < target) emit_token();
    end

    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/nis_pkg.sv
hw/rtl/nis_queue.sv
hw/rtl/nis_front.sv
hw/rtl/nis_back.sv
hw/rtl/number_and_identifier_scanner.sv
hw/rtl/nis_checker.sv
tb/nis_checker.sv
tb/testbench.sv
